// ===== hdl/kse_pkg.sv =====
// Shared types and constants of the kinematic state estimator.
`default_nettype none
package kse_pkg;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [2:0] REG_START_POS   = 3'd0;
  localparam logic [2:0] REG_START_VEL   = 3'd1;
  localparam logic [2:0] REG_START_ACC   = 3'd2;
  localparam logic [2:0] REG_VEL_SMOOTH  = 3'd3;
  localparam logic [2:0] REG_ACC_SMOOTH  = 3'd4;

  localparam logic [15:0] ACC_SMOOTH_RESET = 16'd512;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_VDIV,
    ST_ADIV,
    ST_VSM,
    ST_ASM,
    ST_QMUL,
    ST_QACC,
    ST_QSUM,
    ST_OUT
  } kse_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_item;     // capture input item
    logic decode;        // handle first-update, clear, query-before-sample
    logic div_start;     // start divider with operands for current state
    logic vdiv_done;     // latch raw velocity
    logic adiv_done;     // latch raw acceleration
    logic vsm_done;      // latch smoothed velocity
    logic asm_done;      // commit update
    logic qmul;          // prediction: compute products
    logic qacc;          // prediction: scale dt squared by acceleration
    logic qsum;          // prediction: sum and saturate
    logic publish;       // load output register
  } kse_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic simple;        // item needs no arithmetic
    logic is_query;
  } kse_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -96'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/kinematic_state_estimator.sv =====
// Top level of the kinematic state estimator.
// Each item is a position update, a prediction query or a clear. An update
// runs four passes of one shared restoring divider (raw velocity, raw
// acceleration, two smoothing divisions) before its result is loaded. A
// query steps through the multiply, scale and sum states before its result
// is loaded; a clear, an unused kind, a first update or a query before the
// first sample goes from decode straight to the output state. No new item
// is accepted until the result is loaded, and a result that waits on a
// stall holds off the next item as well. The result register holds while
// stalled.
`default_nettype none
module kinematic_state_estimator
  import kse_pkg::*;
#(
  parameter int MIN_DT_TICKS = 1,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  kind,
  input  wire logic signed [31:0] sample_position,
  input  wire logic        [31:0] sample_time,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      predicted_position,
  output logic signed [31:0]      position_now,
  output logic signed [31:0]      velocity_now,
  output logic signed [31:0]      accel_now,
  output logic                    has_sample,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);
  kse_cmd_t cmd;
  kse_sts_t sts;

  assign cfg_ready = 1'b1;

  kse_ctrl u_ctrl (.clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
                   .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  kse_dp #(.MIN_DT_TICKS(MIN_DT_TICKS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .kind(kind),
    .sample_position(sample_position), .sample_time(sample_time),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .predicted_position(predicted_position), .position_now(position_now),
    .velocity_now(velocity_now), .accel_now(accel_now), .has_sample(has_sample));
endmodule
`default_nettype wire

// ===== hdl/kse_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module kse_div
  import kse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [32:0] den,
  output logic      [63:0] quo,
  output logic             busy
);
  logic [6:0]  count;
  logic [63:0] q;
  logic [33:0] rem;
  logic [33:0] trial;

  assign trial = {rem[32:0], q[63]} - {1'b0, den};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 7'd64;
      q     <= num;
      rem   <= '0;
    end else if (busy) begin
      if (trial[33]) begin
        rem <= {rem[32:0], q[63]};
        q   <= {q[62:0], 1'b0};
      end else begin
        rem <= trial;
        q   <= {q[62:0], 1'b1};
      end
      count <= count - 7'd1;
      if (count == 7'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/kse_ctrl.sv =====
// Sequencing state machine of the estimator.
`default_nettype none
module kse_ctrl
  import kse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire kse_sts_t sts,
  output kse_cmd_t      cmd
);
  kse_state_t state, state_next;
  logic started;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      state <= state_next;
      started <= (state_next != state) ? 1'b0 : 1'b1;
      if (cmd.publish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (sts.simple) state_next = ST_OUT;
        else if (sts.is_query) state_next = ST_QMUL;
        else state_next = ST_VDIV;
      end
      ST_VDIV:   if (started && !sts.div_busy) state_next = ST_ADIV;
      ST_ADIV:   if (started && !sts.div_busy) state_next = ST_VSM;
      ST_VSM:    if (started && !sts.div_busy) state_next = ST_ASM;
      ST_ASM:    if (started && !sts.div_busy) state_next = ST_OUT;
      ST_QMUL:   state_next = ST_QACC;
      ST_QACC:   state_next = ST_QSUM;
      ST_QSUM:   state_next = ST_OUT;
      ST_OUT:    if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = rst || (state != ST_IDLE);
    case (state)
      ST_IDLE:   cmd.load_item = in_valid;
      ST_DECODE: cmd.decode = 1'b1;
      ST_VDIV: begin
        cmd.div_start = !started;
        cmd.vdiv_done = started && !sts.div_busy;
      end
      ST_ADIV: begin
        cmd.div_start = !started;
        cmd.adiv_done = started && !sts.div_busy;
      end
      ST_VSM: begin
        cmd.div_start = !started;
        cmd.vsm_done = started && !sts.div_busy;
      end
      ST_ASM: begin
        cmd.div_start = !started;
        cmd.asm_done = started && !sts.div_busy;
      end
      ST_QMUL:   cmd.qmul = 1'b1;
      ST_QACC:   cmd.qacc = 1'b1;
      ST_QSUM:   cmd.qsum = 1'b1;
      ST_OUT:    cmd.publish = !out_valid || !out_stall;
      default:   cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/kse_dp.sv =====
// Estimator datapath: state registers, divider operands, prediction terms.
`default_nettype none
module kse_dp
  import kse_pkg::*;
#(
  parameter int MIN_DT_TICKS = 1,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kse_cmd_t           cmd,
  output kse_sts_t                sts,
  input  wire logic        [1:0]  kind,
  input  wire logic signed [31:0] sample_position,
  input  wire logic        [31:0] sample_time,
  input  wire logic               cfg_valid,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [31:0] cfg_data,
  output logic signed [31:0]      predicted_position,
  output logic signed [31:0]      position_now,
  output logic signed [31:0]      velocity_now,
  output logic signed [31:0]      accel_now,
  output logic                    has_sample
);
  logic signed [31:0] start_pos, start_vel, start_acc;
  logic [15:0] vel_tc, acc_tc;
  logic signed [31:0] est_pos, est_vel, est_acc;
  logic [31:0] last_time;
  logic awaiting;
  logic [1:0]  it_kind;
  logic signed [31:0] it_pos;
  logic [31:0] it_time, dt;
  logic signed [31:0] raw_v, raw_a, new_v, pred;
  logic simple;
  logic signed [63:0] vprod;
  logic [63:0] aprod;
  logic signed [65:0] vterm, aterm;

  // Divider operand selection.
  logic        div_neg;
  logic signed [64:0] num_s;
  logic [63:0] num_mag, quo;
  logic [32:0] den;
  logic div_busy;
  logic signed [65:0] qs;

  // Phase flags track which division is running.
  logic raw_valid_v, phase_v, phase_a;
  logic div_neg_r;

  // Prediction terms.
  logic [31:0] amag;
  logic [63:0] alo, ahi;
  logic [95:0] afull;
  logic [63:0] vmag;

  kse_div u_div (.clk(clk), .rst(rst), .start(cmd.div_start), .num(num_mag),
                 .den(den), .quo(quo), .busy(div_busy));

  always_comb begin
    num_s = '0;
    den   = {1'b0, dt};
    if (cmd.div_start || cmd.vdiv_done) begin
      num_s = (65'(it_pos) - 65'(est_pos)) <<< FRAC_BITS;
    end
    if (cmd.adiv_done || (cmd.div_start && raw_valid_v)) begin
      num_s = (65'(raw_v) - 65'(est_vel)) <<< FRAC_BITS;
    end
    if (phase_v) begin
      num_s = 65'(raw_v) * 65'sd256 + 65'(est_vel) * $signed({49'd0, vel_tc});
      den   = 33'd256 + 33'(vel_tc);
    end
    if (phase_a) begin
      num_s = 65'(raw_a) * 65'sd256 + 65'(est_acc) * $signed({49'd0, acc_tc});
      den   = 33'd256 + 33'(acc_tc);
    end
    num_mag = num_s[64] ? 64'(-num_s) : num_s[63:0];
  end

  assign div_neg = num_s[64];
  assign qs = div_neg_r ? -$signed({2'b0, quo}) : $signed({2'b0, quo});

  assign simple = (it_kind != KIND_UPDATE && it_kind != KIND_QUERY) || awaiting;
  assign sts.div_busy = div_busy;
  assign sts.simple   = simple;
  assign sts.is_query = (it_kind == KIND_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos <= '0; start_vel <= '0; start_acc <= '0;
      vel_tc <= '0; acc_tc <= ACC_SMOOTH_RESET;
      est_pos <= '0; est_vel <= '0; est_acc <= '0;
      last_time <= '0; awaiting <= 1'b1;
      raw_valid_v <= 1'b0; phase_v <= 1'b0; phase_a <= 1'b0;
      has_sample <= 1'b0;
      position_now <= '0; velocity_now <= '0; accel_now <= '0;
      predicted_position <= '0;
      // start registers reset to zero; the estimate resets to zero by itself
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_START_POS:  start_pos <= cfg_data;
          REG_START_VEL:  start_vel <= cfg_data;
          REG_START_ACC:  start_acc <= cfg_data;
          REG_VEL_SMOOTH: vel_tc <= cfg_data[15:0];
          REG_ACC_SMOOTH: acc_tc <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load_item) begin
        it_kind <= kind; it_pos <= sample_position; it_time <= sample_time;
        pred <= '0;
      end
      if (cmd.decode) begin
        dt <= (it_kind == KIND_UPDATE && !awaiting
               && (it_time - last_time) < 32'(MIN_DT_TICKS))
              ? 32'(MIN_DT_TICKS) : it_time - last_time;
        if (it_kind == KIND_UPDATE && awaiting) begin
          awaiting <= 1'b0; est_pos <= it_pos; last_time <= it_time;
        end
        if (it_kind == KIND_QUERY && awaiting) pred <= est_pos;
        if (it_kind == KIND_CLEAR) begin
          est_pos <= '0; est_vel <= '0; est_acc <= '0;
          last_time <= '0; awaiting <= 1'b1;
        end
      end
      if (cmd.div_start) div_neg_r <= div_neg;
      if (cmd.vdiv_done) begin raw_v <= sat32(96'(qs)); raw_valid_v <= 1'b1; end
      if (cmd.adiv_done) begin
        raw_a <= sat32(96'(qs)); raw_valid_v <= 1'b0; phase_v <= 1'b1;
      end
      if (cmd.vsm_done) begin new_v <= sat32(96'(qs)); phase_v <= 1'b0; phase_a <= 1'b1; end
      if (cmd.asm_done) begin
        est_acc <= sat32(96'(qs)); est_vel <= new_v; est_pos <= it_pos;
        last_time <= it_time; phase_a <= 1'b0;
      end
      if (cmd.qmul) begin
        vprod <= 64'(est_vel) * $signed({1'b0, dt});
        aprod <= dt * dt;
      end
      if (cmd.qacc) begin
        alo <= aprod[31:0] * amag;
        ahi <= aprod[63:32] * amag;
      end
      if (cmd.qsum) pred <= sat32(96'(est_pos) + 96'(vterm) + 96'(aterm));
      if (cmd.publish) begin
        predicted_position <= pred;
        position_now <= (it_kind == KIND_UPDATE || it_kind == KIND_CLEAR)
                        ? ((it_kind == KIND_CLEAR) ? 32'sd0 : it_pos) : est_pos;
        velocity_now <= (it_kind == KIND_CLEAR) ? 32'sd0 : est_vel;
        accel_now    <= (it_kind == KIND_CLEAR) ? 32'sd0 : est_acc;
        has_sample   <= (it_kind == KIND_CLEAR) ? 1'b0
                        : (it_kind == KIND_UPDATE) ? 1'b1 : !awaiting;
      end
    end
  end

  // Velocity product registered; d2 * |a| built from two 32-bit halves of d2.
  assign vmag  = vprod[63] ? 64'(-vprod) : vprod;
  assign amag  = est_acc[31] ? 32'(-est_acc) : est_acc;
  assign afull = {ahi, 32'd0} + 96'(alo);
  always_comb begin
    vterm = vprod[63] ? -66'(vmag >> FRAC_BITS) : 66'(vmag >> FRAC_BITS);
    aterm = est_acc[31] ? -66'(afull >> (2*FRAC_BITS+1))
                        : 66'(afull >> (2*FRAC_BITS+1));
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the kinematic state estimator.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import kse_pkg::*;

  localparam longint unsigned TERM_CAP  = 64'd1 << 62;
  localparam int              MAX_CYCLES = 5000000;
  localparam int              SETTLE     = 400;   // beyond the longest update pass

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] pos;
    logic [31:0] stamp;
  } track_item_t;

  typedef struct {
    logic [31:0] predicted;
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] accel;
    logic        has;
  } estimate_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_UPDATE;
  logic [31:0] sample_position = '0;
  logic [31:0] sample_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] predicted_position, position_now, velocity_now, accel_now;
  logic        has_sample;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_START_POS;
  logic [31:0] cfg_data = '0;

  kinematic_state_estimator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .sample_position(sample_position), .sample_time(sample_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .predicted_position(predicted_position), .position_now(position_now),
    .velocity_now(velocity_now), .accel_now(accel_now), .has_sample(has_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  track_item_t pending_items[$];
  estimate_t   expected_estimates[$];
  int          errors = 0;
  int          cycles = 0;

  // Shadow of the estimator state. Start registers never reach the estimate,
  // so the shadow starts from the estimate's reset values.
  longint      est_pos = 0, est_vel = 0, est_acc = 0;
  logic [31:0] last_stamp = '0;
  bit          awaiting = 1'b1;
  logic [15:0] vel_tc = 16'd0;
  logic [15:0] acc_tc = ACC_SMOOTH_RESET;

  // Knobs that the stimulus process turns phase by phase.
  bit sender_gaps = 1'b0;
  int stall_mode  = 0;
  int hold_off    = 0;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint sat32v(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint div_trunc(input longint n, input longint unsigned d);
    longint unsigned q;
    q = mag(n) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint smooth_to(input longint raw, input longint old,
                                       input logic [15:0] tc);
    longint num;
    num = raw * 256 + old * longint'({48'd0, tc});
    return sat32v(div_trunc(num, 64'd256 + tc));
  endfunction

  // Velocity contribution |v|*dt >> 16, capped, signed back.
  function automatic longint drift_term(input longint v, input longint unsigned dt);
    longint unsigned m;
    m = (mag(v) * dt) >> 16;
    if (m > TERM_CAP) m = TERM_CAP;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Acceleration contribution a*dt^2 / 2^33 in two 32-bit halves.
  function automatic longint curve_term(input longint a, input longint unsigned dt);
    longint unsigned am, d2, lo, hi, t32, m;
    am  = mag(a);
    d2  = dt * dt;
    lo  = (d2 & 64'hFFFF_FFFF) * am;
    hi  = (d2 >> 32) * am;
    t32 = hi + (lo >> 32);
    m   = t32 >> 1;
    if (m > TERM_CAP) m = TERM_CAP;
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Advance the shadow state by one item and return the estimate it yields.
  function automatic estimate_t track(input logic [1:0] k, input logic [31:0] p,
                                      input logic [31:0] t);
    estimate_t       e;
    longint          pos, raw_v, raw_a, old_v, pred;
    longint unsigned dt;
    pos  = longint'(signed'(p));
    pred = 0;
    dt   = {32'd0, t - last_stamp};
    case (k)
      KIND_UPDATE: begin
        if (awaiting) begin
          awaiting   = 1'b0;
          est_pos    = pos;
          last_stamp = t;
        end else begin
          if (dt < 1) dt = 1;
          old_v      = est_vel;
          last_stamp = t;
          raw_v   = sat32v(div_trunc((pos - est_pos) * 65536, dt));
          raw_a   = sat32v(div_trunc((raw_v - old_v) * 65536, dt));
          est_pos = pos;
          est_vel = smooth_to(raw_v, old_v, vel_tc);
          est_acc = smooth_to(raw_a, est_acc, acc_tc);
        end
      end
      KIND_QUERY: begin
        if (awaiting) pred = est_pos;
        else pred = sat32v(est_pos + drift_term(est_vel, dt) + curve_term(est_acc, dt));
      end
      KIND_CLEAR: begin
        est_pos = 0; est_vel = 0; est_acc = 0;
        last_stamp = '0;
        awaiting   = 1'b1;
      end
      default: ;  // unused kind: status only
    endcase
    e.predicted = pred[31:0];
    e.position  = est_pos[31:0];
    e.velocity  = est_vel[31:0];
    e.accel     = est_acc[31:0];
    e.has       = !awaiting;
    return e;
  endfunction

  task automatic push_item(input logic [1:0] k, input logic [31:0] p, input logic [31:0] t);
    track_item_t it;
    it.kind = k; it.pos = p; it.stamp = t;
    pending_items.push_back(it);
  endtask

  // A clear followed by a smooth trajectory with interleaved queries; dt
  // mostly modest, sometimes zero, sometimes long or wrapping past zero.
  task automatic push_track(input int n);
    logic [31:0] t, p;
    int          v, a;
    push_item(KIND_CLEAR, $urandom, $urandom);
    t = $urandom;
    p = $urandom_range(0, 1) ? $urandom : {{16{1'b0}}, 16'($urandom)};
    v = $signed($urandom_range(0, 4000)) - 2000;
    a = $signed($urandom_range(0, 40)) - 20;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       t = t;
        1:       t = t + $urandom;
        2, 3:    t = t + $urandom_range(1, 8);
        default: t = t + $urandom_range(1, 6000);
      endcase
      v = v + a;
      p = p + v * $urandom_range(1, 64);
      if ($urandom_range(0, 3) == 0) push_item(KIND_QUERY, $urandom, t + $urandom_range(0, 70000));
      else if ($urandom_range(0, 30) == 0) push_item(KIND_QUERY, $urandom, $urandom);
      else push_item(KIND_UPDATE, p, t);
    end
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) push_item(2'($urandom_range(0, 3)), $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    // smoothing constants act at once; start values never reach the estimate
    if (idx == REG_VEL_SMOOTH) vel_tc = value[15:0];
    if (idx == REG_ACC_SMOOTH) acc_tc = value[15:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_items.size() != 0 || in_valid || expected_estimates.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Sender: bursts of items, separated by random gaps when sender_gaps is set.
  int  burst_left = 0, gap_left = 0;
  bit  in_taken = 1'b0;
  always @(negedge clk) begin
    track_item_t it;
    if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        kind            <= it.kind;
        sample_position <= it.pos;
        sample_time     <= it.stamp;
        in_valid        <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (sender_gaps) gap_left = $urandom_range(0, 30);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off when asked, otherwise its own stall pattern.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 7;
    if (hold_off > 0) begin
      hold_off--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= (stall_phase < 3);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Monitor: predict on input acceptance, check on result acceptance.
  always @(posedge clk) begin
    estimate_t want;
    cycles++;
    in_taken = in_valid && !in_stall && !rst;
    if (in_taken)
      expected_estimates.push_back(track(kind, sample_position, sample_time));
    if (out_valid && !out_stall && !rst) begin
      if (expected_estimates.size() == 0) begin
        report("result arrived with no item outstanding");
      end else begin
        want = expected_estimates.pop_front();
        if (predicted_position !== want.predicted)
          report($sformatf("predicted_position %h, want %h", predicted_position, want.predicted));
        if (position_now !== want.position)
          report($sformatf("position_now %h, want %h", position_now, want.position));
        if (velocity_now !== want.velocity)
          report($sformatf("velocity_now %h, want %h", velocity_now, want.velocity));
        if (accel_now !== want.accel)
          report($sformatf("accel_now %h, want %h", accel_now, want.accel));
        if (has_sample !== want.has)
          report($sformatf("has_sample %b, want %b", has_sample, want.has));
      end
    end
    if (cycles > MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] vel_set[5];
    logic [15:0] acc_set[5];
    vel_set = '{16'd0, 16'hFFFF, 16'd0, 16'd256, 16'd0};
    acc_set = '{16'd512, 16'hFFFF, 16'd0, 16'd256, 16'd0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Start registers never reach the estimator state; write them anyway.
    write_reg(REG_START_POS, 32'h7FFF_FFFF);
    write_reg(REG_START_VEL, 32'h8000_0000);
    write_reg(REG_START_ACC, $urandom);
    for (int idx = REG_ACC_SMOOTH + 1; idx < 8; idx++) write_reg(3'(idx), $urandom);

    // Directed opening: first-sample handling, zero dt, saturation, wrap, clear.
    push_item(KIND_QUERY,  32'h1234_5678, 32'h0000_1000);
    push_item(KIND_UPDATE, 32'h0001_0000, 32'h0000_1000);
    push_item(KIND_UPDATE, 32'h0002_0000, 32'h0000_1000);
    push_item(KIND_UPDATE, 32'h7FFF_FFFF, 32'h0000_1001);
    push_item(KIND_UPDATE, 32'h8000_0000, 32'h0000_1002);
    push_item(KIND_QUERY,  32'h0,         32'h0000_1003);
    push_item(KIND_QUERY,  32'h0,         32'h0000_1001);
    push_item(KIND_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(2'd3,        32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(KIND_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF);
    push_item(KIND_UPDATE, 32'h7FFF_FFFF, 32'h0000_0000);
    push_item(KIND_QUERY,  32'h0,         32'h8000_0000);
    push_item(KIND_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(KIND_QUERY,  32'h0,         32'h0000_0005);
    push_item(KIND_UPDATE, 32'hFFFF_0000, 32'hFFFF_FFF0);
    push_item(KIND_UPDATE, 32'h0000_0000, 32'h0000_0010);
    push_item(KIND_QUERY,  32'h0,         32'h0001_0010);
    push_item(2'd3,        32'h0,         32'h0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_VEL_SMOOTH, (ph == 4) ? $urandom : {16'd0, vel_set[ph]});
      write_reg(REG_ACC_SMOOTH, (ph == 4) ? $urandom : {16'd0, acc_set[ph]});
      sender_gaps = (ph % 2 == 0);
      stall_mode  = ph % 3;
      if (ph == 1) hold_off = 3000;  // block fills and pushes back on the sender
      for (int b = 0; b < 6; b++) push_track($urandom_range(30, 60));
      push_noise(70);
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
